### rtl/core/mct_pkg.sv
// Shared types, codes and defaults for the missing chunk tracker.
`timescale 1ns / 1ps
`default_nettype none
package mct_pkg;

  localparam int MAX_CHUNKS_DEF  = 64;
  localparam int CHUNK_BYTES_DEF = 508;

  localparam int SIZE_W   = 15;
  localparam int OFFSET_W = 32;
  localparam int RES_W    = 15;
  localparam int OUT_DW   = 16;

  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  localparam logic KIND_RESEND = 1'b0;
  localparam logic KIND_DONE   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DATA,
    ST_END,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic restart;
    logic advance;
  } walk_ctl_t;

  typedef struct packed {
    logic clear;
    logic set;
  } map_ctl_t;

endpackage
`default_nettype wire

### rtl/core/missing_chunk_tracker_core.sv
// Top level of the missing chunk tracker: sequencer, config register and output register.
// A begin item, an unused opcode or a data item at or past the size leaves the sequencer idle.
// Any other data item steps the shared offset adder once per chunk
// until it reaches or passes the item's offset.
// An end marker walks the chunks below the size and waits while the result register stays
// full; the walk emits at most one result per cycle.
// Synchronous active-low reset clears the map, the size register and all control state.
`timescale 1ns / 1ps
`default_nettype none
module missing_chunk_tracker_core
  import mct_pkg::*;
#(
  parameter int MAX_CHUNKS  = MAX_CHUNKS_DEF,
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [SIZE_W-1:0]   cfg_wr_data,   // transfer size in bytes
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [OFFSET_W-1:0] in_tdata,      // chunk_offset
  input  wire logic [1:0]          in_tuser,      // opcode
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OUT_DW-1:0]        out_tdata,     // resend_offset, one zero pad bit
  output logic                     out_tuser,     // kind
  output logic                     out_tlast      // last
);

  localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
  localparam int ACC_W = $clog2(MAX_CHUNKS * CHUNK_BYTES + 1);

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0]   xfer_size_r;
  logic [OFFSET_W-1:0] target_r, target_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [RES_W-1:0]    pend_off_r, pend_off_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_kind_r, out_kind_nxt;
  logic [RES_W-1:0]    out_off_r, out_off_nxt;
  logic                out_last_r, out_last_nxt;

  walk_ctl_t        wctl;
  map_ctl_t         mctl;
  logic [CNT_W-1:0] cnt;
  logic [ACC_W-1:0] acc;
  logic             at_end;
  logic             map_bit;
  logic [31:0]      acc32;
  logic             out_free;
  logic             in_fire;
  logic             in_range;

  mct_walker #(
    .MAX_CHUNKS  (MAX_CHUNKS),
    .CHUNK_BYTES (CHUNK_BYTES),
    .CNT_W       (CNT_W),
    .ACC_W       (ACC_W)
  ) u_walker (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (wctl),
    .cnt    (cnt),
    .acc    (acc),
    .at_end (at_end)
  );

  mct_map #(
    .MAX_CHUNKS (MAX_CHUNKS),
    .IDX_W      (IDX_W)
  ) u_map (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mctl),
    .idx    (cnt[IDX_W-1:0]),
    .bit_rd (map_bit)
  );

  assign acc32    = 32'(acc);
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire  = in_tvalid && in_tready;
  // A chunk belongs to the transfer while its start offset lies below the size.
  assign in_range = !at_end && (acc32 < 32'(xfer_size_r));

  always_comb begin
    state_nxt     = state_r;
    target_nxt    = target_r;
    pend_v_nxt    = pend_v_r;
    pend_off_nxt  = pend_off_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_off_nxt   = out_off_r;
    out_last_nxt  = out_last_r;
    wctl          = '0;
    mctl          = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          target_nxt   = in_tdata;
          wctl.restart = 1'b1;
          pend_v_nxt   = 1'b0;
          case (in_tuser)
            OP_BEGIN: mctl.clear = 1'b1;
            OP_DATA: begin
              if (in_tdata < 32'(xfer_size_r)) begin
                state_nxt = ST_DATA;
              end
            end
            OP_END:  state_nxt = ST_END;
            default: ;
          endcase
        end
      end
      ST_DATA: begin
        if (at_end || acc32 > target_r) begin
          state_nxt = ST_IDLE;
        end else if (acc32 == target_r) begin
          mctl.set  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          wctl.advance = 1'b1;
        end
      end
      ST_END: begin
        if (!in_range) begin
          state_nxt = ST_FLUSH;
        end else if (map_bit) begin
          wctl.advance = 1'b1;
        end else if (!pend_v_r) begin
          pend_v_nxt   = 1'b1;
          pend_off_nxt = acc32[RES_W-1:0];
          wctl.advance = 1'b1;
        end else if (out_free) begin
          // The held request is not the final one, since another chunk is missing.
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_RESEND;
          out_off_nxt   = pend_off_r;
          out_last_nxt  = 1'b0;
          pend_off_nxt  = acc32[RES_W-1:0];
          wctl.advance  = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_kind_nxt  = pend_v_r ? KIND_RESEND : KIND_DONE;
          out_off_nxt   = pend_v_r ? pend_off_r : '0;
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      xfer_size_r <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        xfer_size_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    target_r   <= target_nxt;
    pend_off_r <= pend_off_nxt;
    out_kind_r <= out_kind_nxt;
    out_off_r  <= out_off_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'(out_off_r);
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

### rtl/core/mct_map.sv
// Received-chunk bitmap: one flop per chunk, cleared at once, set and read by index.
`timescale 1ns / 1ps
`default_nettype none
module mct_map
  import mct_pkg::*;
#(
  parameter int MAX_CHUNKS = MAX_CHUNKS_DEF,
  parameter int IDX_W      = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire map_ctl_t         ctl,
  input  wire logic [IDX_W-1:0] idx,
  output logic                  bit_rd
);

  logic [MAX_CHUNKS-1:0] map_r;
  logic [MAX_CHUNKS-1:0] map_nxt;
  logic                  idx_ok;

  assign idx_ok = (int'(idx) < MAX_CHUNKS);

  always_comb begin
    map_nxt = map_r;
    if (ctl.clear) begin
      map_nxt = '0;
    end else if (ctl.set && idx_ok) begin
      map_nxt[idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r <= '0;
    end else begin
      map_r <= map_nxt;
    end
  end

  assign bit_rd = idx_ok ? map_r[idx] : 1'b0;

endmodule
`default_nettype wire

### rtl/core/mct_walker.sv
// Shared stepping unit: chunk index counter and running byte offset (index times chunk size).
`timescale 1ns / 1ps
`default_nettype none
module mct_walker
  import mct_pkg::*;
#(
  parameter int MAX_CHUNKS  = MAX_CHUNKS_DEF,
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
  parameter int CNT_W       = $clog2(MAX_CHUNKS + 1),
  parameter int ACC_W       = $clog2(MAX_CHUNKS * CHUNK_BYTES + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire walk_ctl_t        ctl,
  output logic [CNT_W-1:0]      cnt,
  output logic [ACC_W-1:0]      acc,
  output logic                  at_end
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    if (ctl.restart) begin
      cnt_nxt = '0;
      acc_nxt = '0;
    end else if (ctl.advance) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      acc_nxt = acc_r + ACC_W'(CHUNK_BYTES);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      acc_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign cnt    = cnt_r;
  assign acc    = acc_r;
  assign at_end = (int'(cnt_r) >= MAX_CHUNKS);

endmodule
`default_nettype wire

### rtl/core/mct_checker.sv
// Port-level checker for the missing chunk tracker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mct_checker
  import mct_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tvalid,
  input wire logic              in_tready,
  input wire logic [1:0]        in_tuser,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [OUT_DW-1:0] out_tdata,
  input wire logic              out_tuser,
  input wire logic              out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result item dropped while stalled");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_DONE |-> out_tlast)
    else $error("complete item without last");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_DONE |-> out_tdata == '0)
    else $error("complete item with nonzero offset");

  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_END |=> !in_tready)
    else $error("input ready right after an end marker");

endmodule

bind missing_chunk_tracker_core mct_checker u_mct_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
